// File: design/gvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvn_pkg: shared constants, types and a function for the grid vertex normals block
// Holds the store geometry, the operation codes and the packing of store addresses.
// ----------------------------------------------------------------------------
package gvn_pkg;

	localparam int MaxWidth   = 64;
	localparam int MaxHeight  = 64;
	localparam int ColBits    = $clog2(MaxWidth);
	localparam int RowBits    = $clog2(MaxHeight);
	localparam int AddrBits   = RowBits + ColBits;
	localparam int Depth      = MaxWidth * MaxHeight;
	localparam int PosBits    = 24;
	localparam int PosWord    = 3 * PosBits;
	localparam int NrmBits    = 20;
	localparam int NrmWord    = 3 * NrmBits;
	localparam int DimBits    = 7;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	function automatic logic [AddrBits-1:0] grid_addr(input logic [RowBits-1:0] r,
			input logic [ColBits-1:0] c);
		grid_addr = {r, c};
	endfunction

endpackage

// File: design/gvn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvn_ram: generic single port RAM
// One address per cycle, written when we is high and read every cycle; the read data is registered.
// ----------------------------------------------------------------------------
module gvn_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: design/gvn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvn_norm: iterative vector normalizer
// Shifts the vector so its largest magnitude lies in [2^29, 2^30), takes the
// integer square root of the squared length one bit a cycle with a shared
// multiplier for the squares, then divides each component by restoring
// division one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gvn_norm
	import gvn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] vx,
	input  logic signed [63:0] vy,
	input  logic signed [63:0] vz,
	output logic               done,
	output logic signed [NrmBits-1:0] ox,
	output logic signed [NrmBits-1:0] oy,
	output logic signed [NrmBits-1:0] oz
);
	typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SQ, S_ROOT, S_DIV, S_DONE} st_t;

	st_t         st_q;
	logic [62:0] mag_q [3];
	logic [2:0]  neg_q;
	logic [63:0] sum_q;
	logic [1:0]  k_q;
	logic [63:0] rem_q;
	logic [31:0] res_q;
	logic [5:0]  cnt_q;
	logic [46:0] num_q;
	logic [31:0] den_q;
	logic [46:0] quo_q;
	logic [NrmBits-1:0] out_q [3];

	logic [62:0] m01, m012;
	logic [63:0] sq;
	logic [31:0] mk;
	logic [63:0] trial;
	logic [32:0] dtrial;

	assign m01  = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
	assign m012 = (m01 > mag_q[2]) ? m01 : mag_q[2];
	assign mk   = mag_q[k_q][31:0];
	assign sq   = {32'd0, mk} * {32'd0, mk};
	assign trial = {rem_q[61:0], sum_q[63:62]};
	assign dtrial = {rem_q[31:0], num_q[46]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= (st_q == S_DONE);
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						mag_q[0] <= vx[63] ? 63'(-vx) : vx[62:0];
						mag_q[1] <= vy[63] ? 63'(-vy) : vy[62:0];
						mag_q[2] <= vz[63] ? 63'(-vz) : vz[62:0];
						neg_q <= {vz[63], vy[63], vx[63]};
						st_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// One bit of shift a cycle until the largest lands in range.
					if (m012 == '0) begin
						for (int i = 0; i < 3; i++) out_q[i] <= '0;
						st_q <= S_DONE;
					end else if (m012 >= 63'd1 << 30) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (m012 < 63'd1 << 29) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						sum_q <= '0;
						k_q <= '0;
						st_q <= S_SQ;
					end
				end
				S_SQ: begin
					sum_q <= sum_q + sq;
					if (k_q == 2'd2) begin
						st_q <= S_ROOT;
						rem_q <= '0;
						res_q <= '0;
						cnt_q <= '0;
					end
					k_q <= k_q + 2'd1;
				end
				S_ROOT: begin
					// Digit by digit square root, two radicand bits a cycle.
					sum_q <= {sum_q[61:0], 2'b00};
					if (trial >= {30'd0, res_q, 2'b01}) begin
						rem_q <= trial - {30'd0, res_q, 2'b01};
						res_q <= {res_q[30:0], 1'b1};
					end else begin
						rem_q <= trial;
						res_q <= {res_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						st_q <= S_DIV;
						k_q <= '0;
						cnt_q <= '0;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						den_q <= res_q;
						num_q <= {1'b0, mag_q[k_q][31:0], 14'd0} + {16'd0, res_q[31:1]};
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 6'd1;
					end else begin
						num_q <= {num_q[45:0], 1'b0};
						if (!dtrial[32]) begin
							rem_q <= {31'd0, dtrial};
							quo_q <= {quo_q[45:0], 1'b1};
						end else begin
							rem_q <= {rem_q[62:0], num_q[46]};
							quo_q <= {quo_q[45:0], 1'b0};
						end
						if (cnt_q == 6'd47) begin
							// The last quotient bit is appended here.
							out_q[k_q] <= {quo_q[NrmBits-2:0], ~dtrial[32]};
							cnt_q <= '0;
							if (k_q == 2'd2) st_q <= S_DONE;
							k_q <= k_q + 2'd1;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				S_DONE: begin
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ox = neg_q[0] ? -$signed(out_q[0]) : $signed(out_q[0]);
		oy = neg_q[1] ? -$signed(out_q[1]) : $signed(out_q[1]);
		oz = neg_q[2] ? -$signed(out_q[2]) : $signed(out_q[2]);
	end
endmodule

// File: design/grid_vertex_normals.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_vertex_normals: per-vertex normals of a grid mesh by face averaging
// Stores positions and normals in RAM and computes normals with one shared
// iterative normalizer under a sequencer.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata: op, row, col, pos_x, pos_y, pos_z
// m_axis    out  tdata: norm_x, norm_y, norm_z
// cfg       in   index 0 grid_width, index 1 grid_height
// A write is answered from S_IDLE; a read goes through S_RD and S_RDW, set by the registered RAM read.
// Compute clears the normal store, then walks all cells; each face goes through
// the vertex fetches, cross product, normalizer and accumulation, and the
// final pass normalizes each vertex.
// Reset clears control state only; the stores are undefined until written.
// The result register holds until taken; no transaction is accepted while it is full.
module grid_vertex_normals
	import gvn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [87:0]  s_axis_tdata,  // op, row, col, pos_x, pos_y, pos_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [47:0]  m_axis_tdata,  // norm_x, norm_y, norm_z
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [DimBits-1:0] cfg_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RDW, S_CLR, S_FACE, S_FW, S_FN, S_ACC_RD, S_ACC_WR,
		S_FIN_RD, S_FIN_W, S_FIN_N, S_OUT
	} st_t;

	st_t st_q;
	logic [DimBits-1:0] w_q, h_q;
	logic [1:0] op;
	logic [RowBits-1:0] in_row;
	logic [ColBits-1:0] in_col;
	assign op     = s_axis_tdata[1:0];
	assign in_row = s_axis_tdata[7:2];
	assign in_col = s_axis_tdata[13:8];

	logic [RowBits-1:0] r_q;
	logic [ColBits-1:0] c_q;
	logic       tri_q;
	logic [1:0] v_q;
	logic [AddrBits-1:0] addr_q;
	logic signed [PosBits:0] p_q [3][3];
	logic signed [NrmBits-1:0] f_q [3];
	logic signed [47:0] out_q;

	logic pwe, nwe;
	logic [AddrBits-1:0] paddr, naddr;
	logic [PosWord-1:0] pwdata, prdata;
	logic [NrmWord-1:0] nwdata, nrdata;

	logic [DimBits-1:0] we_w, we_h;
	assign we_w = (w_q < 7'd2) ? 7'd2 : (w_q > 7'(MaxWidth)) ? 7'(MaxWidth) : w_q;
	assign we_h = (h_q < 7'd2) ? 7'd2 : (h_q > 7'(MaxHeight)) ? 7'(MaxHeight) : h_q;

	gvn_ram #(.Width(PosWord), .Depth(Depth)) u_pos (
		.clk(clk), .we(pwe), .addr(paddr), .wdata(pwdata), .rdata(prdata));
	gvn_ram #(.Width(NrmWord), .Depth(Depth)) u_nrm (
		.clk(clk), .we(nwe), .addr(naddr), .wdata(nwdata), .rdata(nrdata));

	// Vertex of the current triangle: (p00,p10,p11) then (p11,p01,p00).
	logic [RowBits-1:0] vr;
	logic [ColBits-1:0] vc;
	always_comb begin
		logic [1:0] sel;
		sel = tri_q ? 2'd2 - v_q : v_q;
		unique case (sel)
			2'd0:    begin vr = r_q;        vc = c_q;        end
			2'd1:    begin vr = r_q + 1'b1; vc = c_q;        end
			default: begin vr = r_q + 1'b1; vc = c_q + 1'b1; end
		endcase
		if (tri_q && v_q == 2'd1) begin
			vr = r_q;
			vc = c_q + 1'b1;
		end
	end

	// Cross product of the edges, one product a cycle through a shared multiplier.
	logic signed [63:0] cr_q [3];
	logic [2:0] mc_q;
	logic signed [PosBits+1:0] e1 [3], e2 [3];
	logic signed [51:0] prod;
	logic signed [PosBits+1:0] ma, mb;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e1[k] = p_q[0][k] - p_q[1][k];
			e2[k] = p_q[2][k] - p_q[1][k];
		end
		unique case (mc_q)
			3'd0: begin ma = e1[1]; mb = e2[2]; end
			3'd1: begin ma = e1[2]; mb = e2[1]; end
			3'd2: begin ma = e1[2]; mb = e2[0]; end
			3'd3: begin ma = e1[0]; mb = e2[2]; end
			3'd4: begin ma = e1[0]; mb = e2[1]; end
			default: begin ma = e1[1]; mb = e2[0]; end
		endcase
		prod = ma * mb;
	end

	logic nstart, ndone;
	logic signed [63:0] nvx, nvy, nvz;
	logic signed [NrmBits-1:0] nox, noy, noz;
	gvn_norm u_norm (.clk(clk), .arst_n(arst_n), .start(nstart),
		.vx(nvx), .vy(nvy), .vz(nvz), .done(ndone), .ox(nox), .oy(noy), .oz(noz));

	logic fin_q;
	assign nvx = fin_q ? 64'(signed'(nrdata[19:0]))  : cr_q[0];
	assign nvy = fin_q ? 64'(signed'(nrdata[39:20])) : cr_q[1];
	assign nvz = fin_q ? 64'(signed'(nrdata[59:40])) : cr_q[2];

	logic nstart_q;
	assign nstart = nstart_q;

	always_comb begin
		pwe = 1'b0; nwe = 1'b0;
		paddr = addr_q; naddr = addr_q;
		pwdata = s_axis_tdata[85:14];
		nwdata = '0;
		if (st_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
			paddr = grid_addr(in_row, in_col);
			naddr = paddr;
			pwe = (op == OP_WRITE);
		end else if (st_q == S_CLR) begin
			nwe = 1'b1;
		end else if (st_q == S_FACE) begin
			paddr = grid_addr(vr, vc);
		end else if (st_q == S_ACC_RD || st_q == S_FN) begin
			naddr = grid_addr(vr, vc);
		end else if (st_q == S_ACC_WR) begin
			naddr = grid_addr(vr, vc);
			nwe = 1'b1;
			nwdata = {20'(signed'(nrdata[59:40]) + f_q[2]),
				20'(signed'(nrdata[39:20]) + f_q[1]),
				20'(signed'(nrdata[19:0]) + f_q[0])};
		end else if (st_q == S_FIN_N && ndone) begin
			nwe = 1'b1;
			nwdata = {noz, noy, nox};
		end
	end

	assign s_axis_tready = (st_q == S_IDLE) && !m_axis_tvalid;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			w_q <= 7'd2;
			h_q <= 7'd2;
			m_axis_tvalid <= 1'b0;
			nstart_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			nstart_q <= (st_q == S_FN && mc_q == 3'd5) || st_q == S_FIN_W;
			if (cfg_we) begin
				if (cfg_index) h_q <= cfg_data;
				else w_q <= cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						out_q <= '0;
						unique case (op_t'(op))
							OP_READ: begin
								st_q <= S_RD;
								addr_q <= grid_addr(in_row, in_col);
							end
							OP_COMPUTE: begin
								st_q <= S_CLR; r_q <= '0; c_q <= '0;
								addr_q <= '0;
							end
							default:    m_axis_tvalid <= 1'b1;
						endcase
					end
				end
				S_RD: st_q <= S_RDW;
				S_RDW: begin
					out_q <= {nrdata[55:40], nrdata[35:20], nrdata[15:0]};
					m_axis_tvalid <= 1'b1;
					st_q <= S_IDLE;
				end
				S_CLR: begin
					if (7'(c_q) == we_w - 7'd1) begin
						c_q <= '0;
						addr_q <= grid_addr(r_q + 1'b1, '0);
						if (7'(r_q) == we_h - 7'd1) begin
							r_q <= '0; tri_q <= 1'b0; v_q <= '0;
							st_q <= S_FACE;
						end else r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
						addr_q <= grid_addr(r_q, c_q + 1'b1);
					end
				end
				S_FACE: st_q <= S_FW;
				S_FW: begin
					for (int k = 0; k < 3; k++)
						p_q[v_q][k] <= (PosBits+1)'(signed'(prdata[k*PosBits +: PosBits]));
					if (v_q == 2'd2) begin
						mc_q <= '0; v_q <= '0; st_q <= S_FN;
					end else begin
						v_q <= v_q + 2'd1; st_q <= S_FACE;
					end
				end
				S_FN: begin
					if (mc_q < 3'd6) begin
						if (!mc_q[0]) cr_q[mc_q[2:1]] <= 64'(prod);
						else cr_q[mc_q[2:1]] <= cr_q[mc_q[2:1]] - 64'(prod);
						mc_q <= mc_q + 3'd1;
					end else if (ndone) begin
						f_q[0] <= nox; f_q[1] <= noy; f_q[2] <= noz;
						v_q <= '0; st_q <= S_ACC_RD;
					end
				end
				S_ACC_RD: st_q <= S_ACC_WR;
				S_ACC_WR: begin
					if (v_q == 2'd2) begin
						v_q <= '0;
						if (!tri_q) begin
							tri_q <= 1'b1; st_q <= S_FACE;
						end else begin
							tri_q <= 1'b0;
							if (7'(c_q) == we_w - 7'd2) begin
								c_q <= '0;
								if (7'(r_q) == we_h - 7'd2) begin
									r_q <= '0; st_q <= S_FIN_RD;
									addr_q <= '0;
								end else begin
									r_q <= r_q + 1'b1; st_q <= S_FACE;
								end
							end else begin
								c_q <= c_q + 1'b1; st_q <= S_FACE;
							end
						end
					end else begin
						v_q <= v_q + 2'd1; st_q <= S_ACC_RD;
					end
				end
				S_FIN_RD: begin
					addr_q <= grid_addr(r_q, c_q);
					st_q <= S_FIN_W;
				end
				S_FIN_W: begin
					fin_q <= 1'b1; st_q <= S_FIN_N;
				end
				S_FIN_N: begin
					if (ndone) begin
						fin_q <= 1'b0;
						if (7'(c_q) == we_w - 7'd1) begin
							c_q <= '0;
							if (7'(r_q) == we_h - 7'd1) begin
								st_q <= S_OUT;
							end else begin
								r_q <= r_q + 1'b1; st_q <= S_FIN_RD;
							end
						end else begin
							c_q <= c_q + 1'b1; st_q <= S_FIN_RD;
						end
					end
				end
				S_OUT: begin
					m_axis_tvalid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
